>>> src/aes_ctr_pkg.sv
// ----------------------------------------------------------------------------
// aes_ctr_pkg: shared types and AES round functions
// Payload structs, pipeline stage record, S-box table and round helpers.
// ----------------------------------------------------------------------------
package aes_ctr_pkg;

  localparam int ROUNDS = 10;

  // register indexes on the configuration port
  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_IV       = 2'd2;
  localparam logic [1:0] REG_NONCE    = 2'd3;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        result_last;
  } out_item_t;

  // one block in flight: cipher state, current round key and the data
  typedef struct packed {
    logic [127:0] state;
    logic [127:0] rkey;
    logic [63:0]  data_high;
    logic [63:0]  data_low;
    logic         last_block;
  } stage_t;

  localparam logic [0:255][7:0] SBOX = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon_of(input logic [3:0] round);
    logic [7:0] r;
    unique case (round)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // byte i of a 128-bit block sits at bits [127-8i -: 8]
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = sub_byte(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      t[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

  function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                  input logic [7:0]   rc);
    logic [31:0] w3, t, n0, n1, n2, n3;
    w3 = k[31:0];
    t  = {sub_byte(w3[23:16]), sub_byte(w3[15:8]), sub_byte(w3[7:0]),
          sub_byte(w3[31:24])} ^ {rc, 24'h0};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

>>> src/aes_ctr_round.sv
// ----------------------------------------------------------------------------
// aes_ctr_round: one round cell of the cipher chain
// Derives the next round key and applies one AES round to the block it holds.
// ----------------------------------------------------------------------------
module aes_ctr_round (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [7:0]          rcon,
  input  logic                final_round,
  input  logic                valid_in,
  input  aes_ctr_pkg::stage_t stage_in,
  output logic                valid_out,
  output aes_ctr_pkg::stage_t stage_out
);
  import aes_ctr_pkg::*;

  logic [127:0] key_next;
  logic [127:0] shifted;
  stage_t       stage_next;

  always_comb begin
    key_next = next_round_key(stage_in.rkey, rcon);
    shifted  = sub_shift(stage_in.state);
    stage_next = stage_in;
    stage_next.rkey  = key_next;
    stage_next.state = (final_round ? shifted : mix_columns(shifted)) ^ key_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_out <= stage_next;
    end
  end

endmodule

>>> src/aes128_ctr_encrypt.sv
// ----------------------------------------------------------------------------
// aes128_ctr_encrypt: AES-128 counter-mode stream cipher
// Counter generator, entry stage and a chain of ten round cells.
// ----------------------------------------------------------------------------
// Usage:
//   Program key_high, key_low, iv_value and nonce_value over the APB port
//   (byte addresses 0, 8, 16, 24; 64-bit data) while the block is idle.
//   Writing iv_value restarts the counter. Blocks enter on in_* as a
//   valid/ready transfer and leave on out_* in the same order.
//   out_valid rises once a transferred block has passed one entry stage
//   that forms the counter block and adds the first round key, then ten
//   round cells, each deriving its own round key from its neighbor's.
//   Throughput is one block per cycle unless stalled; all cells advance together.
//   When the receiver stalls with a result waiting, the whole chain holds,
//   empty slots included, and in_ready drops until the result transfers.
//   Reset clears the settings and the valid bits of the chain; the counter
//   restarts at 1. After a block marked last, the counter reloads from the iv.
// ----------------------------------------------------------------------------
module aes128_ctr_encrypt (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  aes_ctr_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output aes_ctr_pkg::out_item_t out_data
);
  import aes_ctr_pkg::*;

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [63:0] iv_value;
  logic [31:0] nonce_value;
  logic [63:0] counter_tail;

  logic       en;
  logic       wr;
  logic       take;
  logic [1:0] reg_idx;

  logic   valid [0:ROUNDS];
  stage_t stage [0:ROUNDS];

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr      = psel && penable && pwrite;
  assign en      = !valid[ROUNDS] || out_ready;
  assign in_ready = en;
  assign take    = in_valid && en;

  always_comb begin
    unique case (reg_idx)
      REG_KEY_HIGH: prdata = key_high;
      REG_KEY_LOW:  prdata = key_low;
      REG_IV:       prdata = iv_value;
      REG_NONCE:    prdata = {32'h0, nonce_value};
      default:      prdata = 64'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high     <= 64'h0;
      key_low      <= 64'h0;
      iv_value     <= 64'h0;
      nonce_value  <= 32'h0;
      counter_tail <= 64'h1;
    end else begin
      if (wr) begin
        unique case (reg_idx)
          REG_KEY_HIGH: key_high <= pwdata;
          REG_KEY_LOW:  key_low <= pwdata;
          REG_IV: begin
            iv_value     <= pwdata;
            counter_tail <= {pwdata[31:0], 32'h1};
          end
          REG_NONCE:    nonce_value <= pwdata[31:0];
          default:      ;
        endcase
      end
      // advance on each input transfer, restart after the last block
      if (take) begin
        counter_tail <= in_data.last_block ? {iv_value[31:0], 32'h1}
                                           : counter_tail + 64'h1;
      end
    end
  end

  // entry stage: counter block plus round key zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage[0].state      <= {nonce_value, iv_value[63:32], counter_tail} ^
                             {key_high, key_low};
      stage[0].rkey       <= {key_high, key_low};
      stage[0].data_high  <= in_data.data_high;
      stage[0].data_low   <= in_data.data_low;
      stage[0].last_block <= in_data.last_block;
    end
  end

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    aes_ctr_round u_round (
      .clk         (clk),
      .rst         (rst),
      .en          (en),
      .rcon        (rcon_of(4'(g + 1))),
      .final_round (g == ROUNDS - 1),
      .valid_in    (valid[g]),
      .stage_in    (stage[g]),
      .valid_out   (valid[g + 1]),
      .stage_out   (stage[g + 1])
    );
  end

  assign out_valid            = valid[ROUNDS];
  assign out_data.result_high = stage[ROUNDS].data_high ^ stage[ROUNDS].state[127:64];
  assign out_data.result_low  = stage[ROUNDS].data_low ^ stage[ROUNDS].state[63:0];
  assign out_data.result_last = stage[ROUNDS].last_block;

endmodule

>>> src/aes_ctr_checker.sv
// ----------------------------------------------------------------------------
// aes_ctr_checker: port-level checks for the counter-mode cipher
// Watches reset, stall and flow behavior at the top-level ports.
// ----------------------------------------------------------------------------
module aes_ctr_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   pready,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input aes_ctr_pkg::out_item_t out_data
);
  import aes_ctr_pkg::*;

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  // an empty output slot never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with no result waiting");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while chain stalled");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind aes128_ctr_encrypt aes_ctr_checker u_aes_ctr_checker (
  .clk       (clk),
  .rst       (rst),
  .pready    (pready),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
